[hw/rtl/upscl_pkg.sv]
// Package for the pixel replicate upscaler.
// Holds default sizes, register indexes and beat mode codes; depends on nothing.
package upscl_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned MAX_SCALE_DEF = 100;

  localparam int unsigned SCALE_REG_W = 7;
  localparam int unsigned WIDTH_REG_W = 11;
  localparam int unsigned TOTAL_REG_W = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned PIXEL_W     = 3 * COLOR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE = 2'd0,
    REG_WIDTH = 2'd1,
    REG_TOTAL = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_ADVANCE = 1'b1
  } mode_e;

endpackage

[hw/rtl/pixel_replicate_upscale.sv]
// Integer nearest-neighbor upscaler for 24-bit pixel rows.
// Uses upscl_pkg; the line buffer is an internal memory.
//
// Usage: configure scale, row width and row count through the write port
// while the block is idle. Then send load beats (mode 0), one pixel each,
// until a full input row is held; the block then switches to emitting and
// each advance beat (mode 1) produces one output element: every pixel is
// repeated scale times, followed by (width*scale) mod 4 zero pad elements,
// and the whole output row is repeated scale times. end_of_row_o and
// end_of_image_o flag the last element of a scanline and of the image.
// Load beats while emitting and advance beats while loading are dropped.
// Throughput is one beat per cycle on both channels while in_stall_o and
// out_stall_i stay low. An advance beat's result passes through the
// registered line buffer read and then through the output register.
// Reset returns the block to the loading phase with all counters cleared
// and the registers at 1; the line buffer keeps undefined contents.
// When the receiver stalls, the output register holds its beat; one more
// beat can sit in the read stage, after which in_stall_o rises.
module pixel_replicate_upscale #(
  parameter int unsigned MAX_WIDTH = upscl_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_SCALE = upscl_pkg::MAX_SCALE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [upscl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [upscl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             mode_i,
  input  logic [upscl_pkg::COLOR_W-1:0]    blue_i,
  input  logic [upscl_pkg::COLOR_W-1:0]    green_i,
  input  logic [upscl_pkg::COLOR_W-1:0]    red_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             is_pad_o,
  output logic [upscl_pkg::COLOR_W-1:0]    blue_out_o,
  output logic [upscl_pkg::COLOR_W-1:0]    green_out_o,
  output logic [upscl_pkg::COLOR_W-1:0]    red_out_o,
  output logic                             end_of_row_o,
  output logic                             end_of_image_o
);
  import upscl_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned SW = $clog2(MAX_SCALE + 1);

  // Configuration registers.
  logic [SCALE_REG_W-1:0] scale_q;
  logic [WIDTH_REG_W-1:0] width_q;
  logic [TOTAL_REG_W-1:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_REG_W'(1);
      width_q <= WIDTH_REG_W'(1);
      total_q <= TOTAL_REG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SCALE: scale_q <= cfg_data_i[SCALE_REG_W-1:0];
        REG_WIDTH: width_q <= cfg_data_i[WIDTH_REG_W-1:0];
        REG_TOTAL: total_q <= cfg_data_i[TOTAL_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective (clamped) settings.
  logic [SW-1:0]          s_eff;
  logic [WW-1:0]          w_eff;
  logic [TOTAL_REG_W-1:0] t_eff;
  logic [1:0]             pad_cnt;

  always_comb begin
    if (scale_q == '0) begin
      s_eff = SW'(1);
    end else if (32'(scale_q) > 32'(MAX_SCALE)) begin
      s_eff = SW'(MAX_SCALE);
    end else begin
      s_eff = SW'(scale_q);
    end
    if (width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    t_eff   = (total_q == '0) ? TOTAL_REG_W'(1) : total_q;
    pad_cnt = 2'((32'(w_eff) & 32'd3) * (32'(s_eff) & 32'd3));
  end

  // Sequencing state.
  logic [WW-1:0]          load_cnt_q, load_cnt_d;
  logic [WW-1:0]          col_q, col_d;
  logic [SW-1:0]          copy_q, copy_d;
  logic [SW-1:0]          rep_q, rep_d;
  logic [1:0]             pad_idx_q, pad_idx_d;
  logic [TOTAL_REG_W-1:0] rows_q, rows_d;
  logic                   emit_q, emit_d;

  // Pipeline handshake.
  logic out_valid_q;
  logic s1_valid_q;
  logic out_adv;
  logic s1_load;
  logic in_acc;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s1_load    = !s1_valid_q || out_adv;
  assign in_stall_o = !s1_load;
  assign in_acc     = in_valid_i && s1_load;

  logic buf_we;
  logic rd_en;
  logic res_valid;
  logic res_pad;
  logic res_eor;
  logic res_eoi;
  logic row_end;

  always_comb begin
    load_cnt_d = load_cnt_q;
    col_d      = col_q;
    copy_d     = copy_q;
    rep_d      = rep_q;
    pad_idx_d  = pad_idx_q;
    rows_d     = rows_q;
    emit_d     = emit_q;
    buf_we     = 1'b0;
    rd_en      = 1'b0;
    res_valid  = 1'b0;
    res_pad    = 1'b0;
    res_eoi    = 1'b0;
    row_end    = 1'b0;

    if (in_acc && (mode_i == MODE_LOAD) && !emit_q) begin
      buf_we     = 32'(load_cnt_q) < 32'(MAX_WIDTH);
      load_cnt_d = load_cnt_q + WW'(1);
      if (load_cnt_d >= w_eff) begin
        emit_d     = 1'b1;
        load_cnt_d = '0;
        col_d      = '0;
        copy_d     = '0;
        rep_d      = '0;
        pad_idx_d  = '0;
      end
    end else if (in_acc && (mode_i == MODE_ADVANCE) && emit_q) begin
      res_valid = 1'b1;
      if (col_q < w_eff) begin
        rd_en = 32'(col_q) < 32'(MAX_WIDTH);
        if ((32'(copy_q) + 32'd1) >= 32'(s_eff)) begin
          copy_d  = '0;
          col_d   = col_q + WW'(1);
          row_end = (col_d >= w_eff) && (pad_cnt == 2'd0);
        end else begin
          copy_d = copy_q + SW'(1);
        end
      end else begin
        res_pad = 1'b1;
        if ((3'(pad_idx_q) + 3'd1) >= 3'(pad_cnt)) begin
          row_end = 1'b1;
        end else begin
          pad_idx_d = pad_idx_q + 2'd1;
        end
      end

      if (row_end) begin
        col_d     = '0;
        copy_d    = '0;
        pad_idx_d = '0;
        if ((32'(rep_q) + 32'd1) >= 32'(s_eff)) begin
          rep_d      = '0;
          emit_d     = 1'b0;
          load_cnt_d = '0;
          if ((17'(rows_q) + 17'd1) >= 17'(t_eff)) begin
            res_eoi = 1'b1;
            rows_d  = '0;
          end else begin
            rows_d = rows_q + TOTAL_REG_W'(1);
          end
        end else begin
          rep_d = rep_q + SW'(1);
        end
      end
    end
    res_eor = row_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      col_q      <= '0;
      copy_q     <= '0;
      rep_q      <= '0;
      pad_idx_q  <= '0;
      rows_q     <= '0;
      emit_q     <= 1'b0;
    end else begin
      load_cnt_q <= load_cnt_d;
      col_q      <= col_d;
      copy_q     <= copy_d;
      rep_q      <= rep_d;
      pad_idx_q  <= pad_idx_d;
      rows_q     <= rows_d;
      emit_q     <= emit_d;
    end
  end

  // Line buffer: one write port for loads, one registered read port.
  logic [PIXEL_W-1:0] line_mem [MAX_WIDTH];
  logic [PIXEL_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      line_mem[load_cnt_q[AW-1:0]] <= {red_i, green_i, blue_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && rd_en) begin
      rd_q <= line_mem[col_q[AW-1:0]];
    end
  end

  // Read stage: flags travel alongside the buffer read.
  logic s1_pad_q, s1_eor_q, s1_eoi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_pad_q <= res_pad;
      s1_eor_q <= res_eor;
      s1_eoi_q <= res_eoi;
    end
  end

  // Output register.
  logic               pad_q, eor_q, eoi_q;
  logic [PIXEL_W-1:0] pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      pad_q <= s1_pad_q;
      eor_q <= s1_eor_q;
      eoi_q <= s1_eoi_q;
      pix_q <= s1_pad_q ? '0 : rd_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_pad_o       = pad_q;
  assign blue_out_o     = pix_q[COLOR_W-1:0];
  assign green_out_o    = pix_q[2*COLOR_W-1:COLOR_W];
  assign red_out_o      = pix_q[3*COLOR_W-1:2*COLOR_W];
  assign end_of_row_o   = eor_q;
  assign end_of_image_o = eoi_q;

endmodule

[hw/rtl/upscl_checker.sv]
// Port-level checker for the pixel replicate upscaler, with its bind.
// Uses upscl_pkg for field widths; attaches to pixel_replicate_upscale.
module upscl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          is_pad_o,
  input logic [upscl_pkg::COLOR_W-1:0] blue_out_o,
  input logic [upscl_pkg::COLOR_W-1:0] green_out_o,
  input logic [upscl_pkg::COLOR_W-1:0] red_out_o,
  input logic                          end_of_row_o,
  input logic                          end_of_image_o
);
  import upscl_pkg::*;

  // The image ends only on the last element of a scanline.
  a_eoi_eor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_image_o |-> end_of_row_o)
    else $error("end of image without end of row");

  // Pad elements carry a zero pixel.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_pad_o |-> (blue_out_o == '0) && (green_out_o == '0)
                                && (red_out_o == '0))
    else $error("pad element with nonzero pixel");

  // The input side stalls only while a result beat is held back downstream.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with no output backpressure");

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(is_pad_o)
      && $stable(blue_out_o) && $stable(green_out_o) && $stable(red_out_o)
      && $stable(end_of_row_o) && $stable(end_of_image_o))
    else $error("stalled output beat changed");

endmodule

bind pixel_replicate_upscale upscl_checker u_upscl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .is_pad_o       (is_pad_o),
  .blue_out_o     (blue_out_o),
  .green_out_o    (green_out_o),
  .red_out_o      (red_out_o),
  .end_of_row_o   (end_of_row_o),
  .end_of_image_o (end_of_image_o)
);

[test/pixel_replicate_upscale_tb.sv]
// Self-checking testbench for pixel_replicate_upscale: a scoreboard class predicts each
// output beat from the accepted input beats and register writes. Depends on upscl_pkg and the RTL.
module testbench;
  import upscl_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned RANDOM_ITEMS = 560;
  localparam int unsigned NO_LIMIT     = 32'hFFFF_FFFF;
  localparam int unsigned MEM_AW       = $clog2(MAX_WIDTH_DEF);

  typedef struct packed {
    logic               is_pad;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic               end_of_row;
    logic               end_of_image;
  } upscale_elem_t;

  class upscale_scoreboard;
    logic [SCALE_REG_W-1:0] scale_reg;
    logic [WIDTH_REG_W-1:0] width_reg;
    logic [TOTAL_REG_W-1:0] total_reg;
    logic [PIXEL_W-1:0]     line_mem [MAX_WIDTH_DEF];
    int unsigned load_cnt, col, copy_cnt, rep_cnt, pad_idx, rows_cnt;
    bit emitting;
    int unsigned row_groups_done;
    int unsigned errors;
    upscale_elem_t expected_q[$];

    function new();
      scale_reg = SCALE_REG_W'(1);
      width_reg = WIDTH_REG_W'(1);
      total_reg = TOTAL_REG_W'(1);
      load_cnt = 0;
      col = 0;
      copy_cnt = 0;
      rep_cnt = 0;
      pad_idx = 0;
      rows_cnt = 0;
      emitting = 0;
      row_groups_done = 0;
      errors = 0;
    endfunction

    function int unsigned eff_scale();
      if (scale_reg == '0) return 1;
      if (32'(scale_reg) > MAX_SCALE_DEF) return MAX_SCALE_DEF;
      return 32'(scale_reg);
    endfunction

    function int unsigned eff_width();
      if (width_reg == '0) return 1;
      if (32'(width_reg) > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return 32'(width_reg);
    endfunction

    function int unsigned eff_total();
      return (total_reg == '0) ? 1 : 32'(total_reg);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SCALE: scale_reg = data[SCALE_REG_W-1:0];
        REG_WIDTH: width_reg = data[WIDTH_REG_W-1:0];
        REG_TOTAL: total_reg = data[TOTAL_REG_W-1:0];
        default: ;
      endcase
    endfunction

    // Returns 1 when the beat did something, 0 when the block drops it.
    function bit note_beat(mode_e m, logic [COLOR_W-1:0] b, logic [COLOR_W-1:0] g,
                           logic [COLOR_W-1:0] r);
      int unsigned s, w, pad;
      upscale_elem_t e;
      bit row_end;
      s = eff_scale();
      w = eff_width();
      pad = ((w & 3) * (s & 3)) & 3;
      e = '0;
      row_end = 0;
      if (m == MODE_LOAD) begin
        if (emitting) return 0;
        if (load_cnt < MAX_WIDTH_DEF) line_mem[load_cnt[MEM_AW-1:0]] = {r, g, b};
        load_cnt++;
        if (load_cnt >= w) begin
          emitting = 1;
          load_cnt = 0;
          col = 0;
          copy_cnt = 0;
          rep_cnt = 0;
          pad_idx = 0;
        end
        return 1;
      end
      if (!emitting) return 0;
      if (col < w) begin
        {e.red, e.green, e.blue} = line_mem[col[MEM_AW-1:0]];
        if (copy_cnt + 1 >= s) begin
          copy_cnt = 0;
          col++;
          row_end = (col >= w) && (pad == 0);
        end else begin
          copy_cnt++;
        end
      end else begin
        // Past the pixels: pad bytes, or a lone pad beat if the pad count dropped to zero.
        e.is_pad = 1;
        if (pad_idx + 1 >= pad) row_end = 1;
        else pad_idx++;
      end
      if (row_end) begin
        col = 0;
        copy_cnt = 0;
        pad_idx = 0;
        if (rep_cnt + 1 >= s) begin
          rep_cnt = 0;
          emitting = 0;
          load_cnt = 0;
          row_groups_done++;
          if (rows_cnt + 1 >= eff_total()) begin
            e.end_of_image = 1;
            rows_cnt = 0;
          end else begin
            rows_cnt++;
          end
        end else begin
          rep_cnt++;
        end
      end
      e.end_of_row = row_end;
      expected_q.push_back(e);
      return 1;
    endfunction

    function void check_result(upscale_elem_t got);
      upscale_elem_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output beat: pad=%0d r=%02h g=%02h b=%02h eor=%0d eoi=%0d",
                   got.is_pad, got.red, got.green, got.blue, got.end_of_row,
                   got.end_of_image);
        return;
      end
      want = expected_q.pop_front();
      if (got.is_pad !== want.is_pad || got.blue !== want.blue || got.green !== want.green ||
          got.red !== want.red || got.end_of_row !== want.end_of_row ||
          got.end_of_image !== want.end_of_image) begin
        errors++;
        if (errors <= 10) begin
          $display("output mismatch: expected pad=%0d r=%02h g=%02h b=%02h eor=%0d eoi=%0d",
                   want.is_pad, want.red, want.green, want.blue, want.end_of_row,
                   want.end_of_image);
          $display("                 actual   pad=%0d r=%02h g=%02h b=%02h eor=%0d eoi=%0d",
                   got.is_pad, got.red, got.green, got.blue, got.end_of_row,
                   got.end_of_image);
        end
      end
    endfunction
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic                  mode_i      = 1'b0;
  logic [COLOR_W-1:0]    blue_i      = '0;
  logic [COLOR_W-1:0]    green_i     = '0;
  logic [COLOR_W-1:0]    red_i       = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  is_pad_o;
  logic [COLOR_W-1:0]    blue_out_o;
  logic [COLOR_W-1:0]    green_out_o;
  logic [COLOR_W-1:0]    red_out_o;
  logic                  end_of_row_o;
  logic                  end_of_image_o;

  upscale_scoreboard sb;
  int unsigned send_idle_pct = 24;
  int unsigned recv_idle_pct = 75;
  int unsigned results_seen  = 0;
  int unsigned hold_left     = 0;

  pixel_replicate_upscale DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .blue_i        (blue_i),
    .green_i       (green_i),
    .red_i         (red_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .is_pad_o      (is_pad_o),
    .blue_out_o    (blue_out_o),
    .green_out_o   (green_out_o),
    .red_out_o     (red_out_o),
    .end_of_row_o  (end_of_row_o),
    .end_of_image_o(end_of_image_o)
  );

  always #4 clk_i = ~clk_i;

  // Output side: check every accepted beat and pick the stall for the next cycle.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      sb.check_result(upscale_elem_t'({is_pad_o, blue_out_o, green_out_o, red_out_o,
                                       end_of_row_o, end_of_image_o}));
      results_seen++;
      // Now and then hold off for a long stretch so the block fills and stalls its input.
      if (results_seen % 4000 == 100) hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic send_beat(input mode_e m, input logic [COLOR_W-1:0] b,
                           input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r,
                           output bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    blue_i     <= b;
    green_i    <= g;
    red_i      <= r;
    do @(posedge clk_i); while (in_stall_o);
    counted = sb.note_beat(m, b, g, r);
  endtask

  // Well-formed beats for the current phase with some wrong-phase beats mixed in.
  // Stops after max_items useful beats or max_groups finished output row groups.
  task automatic send_mix(input int unsigned max_items, input int unsigned max_groups,
                          input int unsigned noise_pct, output int unsigned sent);
    int unsigned start_groups;
    mode_e m;
    bit counted;
    sent = 0;
    start_groups = sb.row_groups_done;
    while (sent < max_items && (sb.row_groups_done - start_groups) < max_groups) begin
      m = sb.emitting ? MODE_ADVANCE : MODE_LOAD;
      if ($urandom_range(99) < noise_pct) m = (m == MODE_LOAD) ? MODE_ADVANCE : MODE_LOAD;
      send_beat(m, COLOR_W'($urandom_range(255)), COLOR_W'($urandom_range(255)),
                COLOR_W'($urandom_range(255)), counted);
      if (counted) sent++;
    end
  endtask

  // Waits until every predicted beat is out, then lets any beats still in flight come out too.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    bit counted;
    int unsigned sent, random_done, seg;
    logic [CFG_DATA_W-1:0] data;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: one pixel per row, scale one, one row per image.
    send_beat(MODE_ADVANCE, 8'h00, 8'h00, 8'h00, counted);
    send_beat(MODE_LOAD, 8'hFF, 8'hFF, 8'hFF, counted);
    send_beat(MODE_LOAD, 8'h12, 8'h34, 8'h56, counted);
    repeat (2) send_beat(MODE_ADVANCE, 8'hFF, 8'hFF, 8'hFF, counted);
    settle();

    // Zero registers are used as one; width three gives three pad bytes.
    write_reg(REG_SCALE, 16'h0000);
    write_reg(REG_WIDTH, 16'h0003);
    write_reg(REG_TOTAL, 16'h0000);
    send_beat(MODE_LOAD, 8'h00, 8'h00, 8'h00, counted);
    send_beat(MODE_LOAD, 8'hAA, 8'h55, 8'hF0, counted);
    send_beat(MODE_LOAD, 8'h55, 8'hAA, 8'h0F, counted);
    repeat (3) send_beat(MODE_ADVANCE, 8'h00, 8'h00, 8'h00, counted);
    settle();
    // In the pad part; scale four leaves no pad bytes, so one pad beat closes the row.
    write_reg(REG_SCALE, 16'd4);
    send_beat(MODE_ADVANCE, 8'h00, 8'h00, 8'h00, counted);
    settle();
    // Narrower row and scale one mid-group: the next row ends the group and the image.
    write_reg(REG_WIDTH, 16'd2);
    write_reg(REG_SCALE, 16'd1);
    repeat (4) send_beat(MODE_ADVANCE, 8'h00, 8'h00, 8'h00, counted);
    settle();

    // Widest row and a clamped width, both cut short while loading; a narrow width
    // then lets the next load start the output row.
    write_reg(REG_WIDTH, 16'd1024);
    write_reg(REG_SCALE, 16'd1);
    write_reg(REG_TOTAL, 16'hFFFF);
    send_mix(400, NO_LIMIT, 3, sent);
    settle();
    write_reg(REG_WIDTH, 16'h07FF);
    write_reg(REG_SCALE, 16'h0000);
    write_reg(REG_TOTAL, 16'd2);
    send_mix(300, NO_LIMIT, 3, sent);
    settle();
    write_reg(REG_WIDTH, 16'd5);
    send_mix(NO_LIMIT, 1, 3, sent);
    settle();

    // Largest scale: clamped from the top of the field, then exact, then cut down mid-row.
    write_reg(REG_WIDTH, 16'd1);
    write_reg(REG_SCALE, 16'h007F);
    write_reg(REG_TOTAL, 16'd1);
    send_mix(150, NO_LIMIT, 3, sent);
    settle();
    write_reg(REG_SCALE, 16'd100);
    send_mix(100, NO_LIMIT, 3, sent);
    settle();
    write_reg(REG_SCALE, 16'd3);
    send_mix(NO_LIMIT, 1, 3, sent);
    settle();

    random_done = 0;
    while (random_done < RANDOM_ITEMS) begin
      if (random_done < RANDOM_ITEMS / 3) begin
        send_idle_pct = 24;
        recv_idle_pct = 75;
      end else if (random_done < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 75;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      seg = $urandom_range(40, 200);
      send_mix(seg, NO_LIMIT, 6, sent);
      random_done += sent;
      settle();

      // Small random settings; the width never grows while a row is being sent out.
      if ($urandom_range(1) == 0) begin
        data = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(16'hFFFF)) : 16'h0000;
        data[SCALE_REG_W-1:0] = SCALE_REG_W'($urandom_range(0, 4));
        write_reg(REG_SCALE, data);
      end
      if ($urandom_range(1) == 0) begin
        data = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(16'hFFFF)) : 16'h0000;
        data[WIDTH_REG_W-1:0] = WIDTH_REG_W'(sb.emitting ? $urandom_range(0, sb.eff_width())
                                                         : $urandom_range(0, 13));
        write_reg(REG_WIDTH, data);
      end
      if ($urandom_range(1) == 0) begin
        data = ($urandom_range(7) == 0) ? 16'hFFFF : CFG_DATA_W'($urandom_range(0, 4));
        write_reg(REG_TOTAL, data);
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
